@@ rtl/core/uwp_pkg.sv @@
// Shared types, codes and default sizes of the micro-tag way predictor.
package uwp_pkg;

  localparam int NUM_SETS_DEFAULT = 64;
  localparam int ASSOC_DEFAULT    = 8;
  localparam int MTAG_W_DEFAULT   = 8;

  localparam int SET_INDEX_W = 6;
  localparam int LINE_TAG_W  = 40;
  localparam int WAY_FIELD_W = 3;
  localparam int SET_INDEX_N = 2 ** SET_INDEX_W;

  typedef logic [SET_INDEX_W-1:0] set_index_t;
  typedef logic [LINE_TAG_W-1:0]  line_tag_t;
  typedef logic [WAY_FIELD_W-1:0] way_t;

  typedef enum logic [0:0] {
    CMD_PREDICT = 1'b0,
    CMD_TRAIN   = 1'b1
  } cmd_t;

  typedef struct packed {
    cmd_t       cmd;
    set_index_t set_index;
    line_tag_t  line_tag;
    logic       pred_found;
    way_t       pred_way;
    way_t       true_way;
    logic       cache_hit;
  } in_t;

  typedef struct packed {
    logic found;
    way_t way;
  } out_t;

endpackage

@@ rtl/core/uwp_row_ram.sv @@
// Single-port-write, registered-read memory holding one predictor row per set.
module uwp_row_ram #(
  parameter int DEPTH  = 64,
  parameter int WIDTH  = 72,
  parameter int ADDR_W = 6
) (
  input  logic              clk,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WIDTH-1:0]  rd_data,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ rtl/core/uwp_row_update.sv @@
// Row compare and training update: lowest matching way and the corrected row.
module uwp_row_update import uwp_pkg::*; #(
  parameter int ASSOC  = ASSOC_DEFAULT,
  parameter int MTAG_W = MTAG_W_DEFAULT
) (
  input  in_t                                 item,
  input  logic [ASSOC-1:0]                    row_valid,
  input  logic [ASSOC-1:0][MTAG_W-1:0]        row_tags,
  output out_t                                res,
  output logic [ASSOC-1:0]                    new_valid,
  output logic [ASSOC-1:0][MTAG_W-1:0]        new_tags
);

  localparam int WAY_W = (ASSOC > 1) ? $clog2(ASSOC) : 1;

  logic [MTAG_W-1:0] utag;
  logic [ASSOC-1:0]  match;

  assign utag = item.line_tag[MTAG_W-1:0] ^ item.line_tag[2*MTAG_W-1:MTAG_W];

  always_comb begin
    for (int i = 0; i < ASSOC; i++) begin
      match[i] = row_valid[i] && (row_tags[i] == utag);
    end
  end

  always_comb begin
    res.found = 1'b0;
    res.way   = '0;
    for (int i = ASSOC - 1; i >= 0; i--) begin
      if (match[i]) begin
        res.found = 1'b1;
        res.way   = way_t'(i);
      end
    end
  end

  always_comb begin
    logic             pw_ok;
    logic             aw_ok;
    logic             mispredict;
    logic [WAY_W-1:0] pw;
    logic [WAY_W-1:0] aw;
    pw_ok      = int'(item.pred_way) < ASSOC;
    aw_ok      = int'(item.true_way) < ASSOC;
    pw         = WAY_W'(item.pred_way);
    aw         = WAY_W'(item.true_way);
    mispredict = item.pred_found && (item.pred_way != item.true_way);
    new_valid  = row_valid;
    new_tags   = row_tags;
    if (mispredict && pw_ok) begin
      new_valid[pw] = 1'b0;
    end
    if ((!item.pred_found || mispredict) && item.cache_hit && aw_ok) begin
      new_valid[aw] = 1'b1;
      new_tags[aw]  = utag;
    end
  end

endmodule

@@ rtl/core/utag_way_predictor.sv @@
// Top level of the micro-tag way predictor: sequencer, row memory and output register.
//
//   channel | dir | handshake          | payload
//   in      | in  | in_valid/in_stall   | in_item  (in_t)
//   out     | out | out_valid/out_stall | out_item (out_t)
//
// Each item is handled as one memory read of the set's row, then the
// compare (predict) or the row write-back (train) on the memory's write port.
// After reset a clearing pass writes every row once, with the input stalled.
// A predict result sits in the output register; the next item is taken while
// it waits, and a later predict holds in its compare cycle until the
// register frees.
module utag_way_predictor import uwp_pkg::*; #(
  parameter int NUM_SETS = NUM_SETS_DEFAULT,
  parameter int ASSOC    = ASSOC_DEFAULT,
  parameter int MTAG_W   = MTAG_W_DEFAULT
) (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  input  in_t  in_item,
  output logic out_valid,
  input  logic out_stall,
  output out_t out_item
);

  localparam int SET_W = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
  localparam int ROW_W = ASSOC * (MTAG_W + 1);

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOKUP
  } state_t;

  state_t           state;
  logic [SET_W-1:0] clr_idx;
  logic [SET_W-1:0] item_set;
  in_t              item;

  logic [SET_W-1:0] set_map [SET_INDEX_N];

  logic             rd_en;
  logic [ROW_W-1:0] rd_data;
  logic             wr_en;
  logic [SET_W-1:0] wr_addr;
  logic [ROW_W-1:0] wr_data;

  logic [ASSOC-1:0]             row_valid;
  logic [ASSOC-1:0][MTAG_W-1:0] row_tags;
  logic [ASSOC-1:0]             new_valid;
  logic [ASSOC-1:0][MTAG_W-1:0] new_tags;
  out_t                         res;
  logic                         out_free;
  logic                         accept;
  logic                         load_out;

  for (genvar g = 0; g < SET_INDEX_N; g++) begin : g_set_map
    assign set_map[g] = SET_W'(g % NUM_SETS);
  end

  assign in_stall  = (state != ST_IDLE);
  assign accept    = in_valid && !in_stall;
  assign rd_en     = accept;
  assign out_free  = !out_valid || !out_stall;
  assign load_out  = (state == ST_LOOKUP) && (item.cmd == CMD_PREDICT) && out_free;

  assign row_valid = rd_data[ROW_W-1 -: ASSOC];
  assign row_tags  = rd_data[ASSOC*MTAG_W-1:0];

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = item_set;
    wr_data = {new_valid, new_tags};
    case (state)
      ST_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = clr_idx;
        wr_data = '0;
      end
      ST_LOOKUP: begin
        wr_en = (item.cmd == CMD_TRAIN);
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

  uwp_row_ram #(
    .DEPTH  (NUM_SETS),
    .WIDTH  (ROW_W),
    .ADDR_W (SET_W)
  ) u_ram (
    .clk     (clk),
    .rd_en   (rd_en),
    .rd_addr (set_map[in_item.set_index]),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  uwp_row_update #(
    .ASSOC  (ASSOC),
    .MTAG_W (MTAG_W)
  ) u_update (
    .item      (item),
    .row_valid (row_valid),
    .row_tags  (row_tags),
    .res       (res),
    .new_valid (new_valid),
    .new_tags  (new_tags)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      clr_idx   <= '0;
      out_valid <= 1'b0;
    end else begin
      if (load_out) begin
        out_valid <= 1'b1;
        out_item  <= res;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_CLEAR: begin
          clr_idx <= clr_idx + 1'b1;
          if (clr_idx == SET_W'(NUM_SETS - 1)) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (accept) begin
            item     <= in_item;
            item_set <= set_map[in_item.set_index];
            state    <= ST_LOOKUP;
          end
        end
        ST_LOOKUP: begin
          if (item.cmd == CMD_TRAIN || out_free) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

@@ rtl/core/uwp_checker.sv @@
// Port-level checks of the way predictor, bound to the top level.
module uwp_checker import uwp_pkg::*; (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_stall,
  input in_t  in_item,
  input logic out_valid,
  input logic out_stall,
  input out_t out_item
);

  logic in_acc;
  assign in_acc = in_valid && !in_stall;

  a_reset_stall: assert property (@(posedge clk) rst |=> in_stall)
    else $error("input not stalled after reset");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_acc |=> in_stall)
    else $error("item accepted while another is in flight");

  a_result_from_predict: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_acc && in_item.cmd == CMD_PREDICT, 2))
    else $error("result without a predict item two cycles earlier");

  a_train_silent: assert property (@(posedge clk) disable iff (rst)
    (in_acc && in_item.cmd == CMD_TRAIN) |-> ##2 !$rose(out_valid))
    else $error("train item produced a result");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(out_item)))
    else $error("stalled result changed");

endmodule

bind utag_way_predictor uwp_checker u_uwp_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_item   (in_item),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_item  (out_item)
);
